>>> sv/lerp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear interpolation weight block.
// No dependencies.
package lerp_pkg;
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  // |num| fits 33 bits; dividend = 2*|num|*2^16 + |den|, divisor = 2*|den|
  localparam int MAG_W      = VAL_W + 1;
  localparam int DIVIDEND_W = MAG_W + FRAC_W + 2;
  localparam int DIVISOR_W  = MAG_W + 1;
  localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_EQUAL = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [VAL_W-1:0] val_t;
endpackage

>>> sv/lerp_mem.sv
`timescale 1ns / 1ps
// Breakpoint table: one write port, one read port with registered data.
// Depends on lerp_pkg.
module lerp_mem (
  input  logic           clk,
  input  logic           wr_en,
  input  lerp_pkg::idx_t wr_addr,
  input  lerp_pkg::val_t wr_data,
  input  lerp_pkg::idx_t rd_addr,
  output lerp_pkg::val_t rd_data
);
  lerp_pkg::val_t mem [lerp_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> sv/lerp_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lerp_pkg.
module lerp_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [lerp_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [lerp_pkg::DIVISOR_W-1:0]      divisor,
  output logic                                done,
  output logic [lerp_pkg::DIVIDEND_W-1:0]     quotient
);
  logic [lerp_pkg::DIVISOR_W:0]   rem;
  logic [lerp_pkg::DIVISOR_W-1:0] dvs;
  logic [lerp_pkg::STEP_W-1:0]    steps;
  logic                           busy;
  logic [lerp_pkg::DIVISOR_W:0]   rem_sh;
  logic                           fits;

  assign rem_sh = {rem[lerp_pkg::DIVISOR_W-1:0], quotient[lerp_pkg::DIVIDEND_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= lerp_pkg::STEP_W'(lerp_pkg::DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == lerp_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      quotient <= {quotient[lerp_pkg::DIVIDEND_W-2:0], fits};
    end
  end
endmodule

>>> sv/linear_interp_weights_top.sv
`timescale 1ns / 1ps
// Interpolation weights over a breakpoint table; uses lerp_pkg, lerp_mem, lerp_div.
// Query: a scan over the table port (one read per point in use), reads of the bracketing
// pair, the divider's 51 quotient bits plus done (skipped on equal breakpoints), then the
// output register; one query at a time; input stalls while a query runs or its result
// waits.
// Synchronous active-high reset clears control state and sets point_count to 2.
module linear_interp_weights_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // table_index[3:0], breakpoint_value[35:4], sample_x[67:36]
  input  logic        s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // lower_index, upper_index, lower_weight, upper_weight, status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_RDLO = 3'd2,
                         S_RDHI = 3'd3, S_DIV = 3'd4, S_FIN = 3'd5;
  localparam int NUM_W = lerp_pkg::MAG_W;
  localparam int RAT_W = lerp_pkg::DIVIDEND_W + 2;

  logic [2:0] state;
  logic [4:0] point_count;
  lerp_pkg::val_t x;
  lerp_pkg::val_t p0;
  lerp_pkg::idx_t ridx, nlast, lo, hi;
  logic [lerp_pkg::CNT_W-1:0] cnt, cnt_fin;
  logic neg, equal;
  lerp_pkg::idx_t rd_addr;
  lerp_pkg::val_t rd_data;
  logic wr_en;
  logic div_start, div_done;
  logic [lerp_pkg::DIVIDEND_W-1:0] dividend, quotient;
  logic [lerp_pkg::DIVISOR_W-1:0] divisor;
  logic signed [NUM_W-1:0] num, den;
  logic [NUM_W-1:0] an, ad;
  logic [lerp_pkg::CNT_W-1:0] n_clamp;
  lerp_pkg::idx_t hi_calc;
  logic signed [RAT_W-1:0] ratio, lwf;
  logic [31:0] uw, lw;
  logic [1:0] status;
  logic sat_u, sat_l;
  logic s_acc;
  logic out_load;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {27'd0, point_count};
  assign s_tready = (state == S_IDLE);
  assign s_acc = s_tvalid && s_tready;
  assign wr_en = s_acc && (s_tuser == lerp_pkg::OP_WRITE);
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    if (point_count < 5'd2) n_clamp = 5'd2;
    else if (point_count > 5'(lerp_pkg::MAX_POINTS)) n_clamp = 5'(lerp_pkg::MAX_POINTS);
    else n_clamp = point_count;
  end

  assign cnt_fin = cnt + {4'd0, (rd_data < x)};
  always_comb begin
    if (cnt_fin < 5'd1) hi_calc = 4'd1;
    else if (cnt_fin > {1'b0, nlast}) hi_calc = nlast;
    else hi_calc = cnt_fin[lerp_pkg::IDX_W-1:0];
  end

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = '0;
      S_SCAN:  rd_addr = (ridx == nlast) ? hi_calc - 1'b1 : ridx + 1'b1;
      S_RDLO:  rd_addr = hi;
      default: rd_addr = hi;
    endcase
  end

  assign num = {x[31], x} - {p0[31], p0};
  assign den = {rd_data[31], rd_data} - {p0[31], p0};
  assign an = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign ad = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
  assign dividend = {1'b0, an, 17'd0} + {18'd0, ad};
  assign divisor = {ad, 1'b0};
  assign div_start = (state == S_RDHI) && (den != '0);

  assign ratio = neg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
  assign lwf = RAT_W'(65536) - ratio;
  always_comb begin
    sat_u = 1'b0;
    sat_l = 1'b0;
    if (ratio > RAT_W'(64'sh7FFFFFFF)) begin
      uw = 32'h7FFFFFFF; sat_u = 1'b1;
    end else if (ratio < -RAT_W'(64'sh80000000)) begin
      uw = 32'h80000000; sat_u = 1'b1;
    end else uw = ratio[31:0];
    if (lwf > RAT_W'(64'sh7FFFFFFF)) begin
      lw = 32'h7FFFFFFF; sat_l = 1'b1;
    end else if (lwf < -RAT_W'(64'sh80000000)) begin
      lw = 32'h80000000; sat_l = 1'b1;
    end else lw = lwf[31:0];
    if (equal) status = lerp_pkg::ST_EQUAL;
    else if (sat_u || sat_l) status = lerp_pkg::ST_SAT;
    else status = lerp_pkg::ST_OK;
  end

  lerp_mem u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(s_tdata[3:0]), .wr_data(s_tdata[35:4]),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  lerp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend), .divisor(divisor),
    .done(div_done), .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 5'd2;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      point_count <= pwdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_acc && s_tuser == lerp_pkg::OP_QUERY) begin
            x <= s_tdata[67:36];
            nlast <= lerp_pkg::IDX_W'(n_clamp - 1'b1);
            ridx <= '0;
            cnt <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt_fin;
          ridx <= ridx + 1'b1;
          if (ridx == nlast) begin
            hi <= hi_calc;
            lo <= hi_calc - 1'b1;
            state <= S_RDLO;
          end
        end
        S_RDLO: begin
          p0 <= rd_data;
          state <= S_RDHI;
        end
        S_RDHI: begin
          neg <= num[NUM_W-1] != den[NUM_W-1];
          equal <= (den == '0);
          state <= (den == '0) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            m_tdata <= {6'd0, status, equal ? 32'd0 : uw, equal ? 32'd0 : lw, hi, lo};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for linear_interp_weights_top: breakpoint writes and weight queries
// on the stream port, point_count over the APB port. Depends on lerp_pkg and the RTL only.
module testbench;

  localparam int  SETTLE    = 120;      // drain wait, longer than one query
  localparam longint LIMIT  = 1000000;

  typedef struct {
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [31:0] lw;
    logic [31:0] uw;
    logic [1:0]  st;
  } weights_t;

  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    bit          typed;
    weights_t    w;
  } stim_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // table_index, breakpoint_value, sample_x
  logic        s_tuser = 0;   // op
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;       // lower_index, upper_index, lower_weight, upper_weight, status
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  linear_interp_weights_top dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] bp_tbl [lerp_pkg::MAX_POINTS];
  logic [4:0]         count_reg = 5'd2;
  weights_t           pending_q [$];
  stim_t              directed [$];
  int                 errors = 0;
  int                 n_results = 0;
  int                 n_items = 0;
  int                 hold_cycles = 0;
  int                 hold_req = 0;
  int                 hold_seen = 0;
  longint             cycles = 0;

  function automatic weights_t interp_weights(input logic signed [31:0] x);
    weights_t r;
    int n, hi, lo;
    longint p0, p1, num, den, ratio, lw, uw;
    longint unsigned an, ad, q;
    bit neg, sat;
    n = count_reg < 2 ? 2 :
        (count_reg > lerp_pkg::MAX_POINTS ? lerp_pkg::MAX_POINTS : count_reg);
    hi = 0;
    sat = 0;
    for (int i = 0; i < n; i++)
      if (longint'(bp_tbl[i]) < longint'(x)) hi++;
    if (hi < 1) hi = 1;
    if (hi > n - 1) hi = n - 1;
    lo = hi - 1;
    p0 = bp_tbl[lo];
    p1 = bp_tbl[hi];
    num = longint'(x) - p0;
    den = p1 - p0;
    r.lo = lo[3:0];
    r.hi = hi[3:0];
    if (den == 0) begin
      r.lw = '0;
      r.uw = '0;
      r.st = lerp_pkg::ST_EQUAL;
    end else begin
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      an = an * 65536;
      neg = (num < 0) != (den < 0);
      q = (2 * an + ad) / (2 * ad);
      ratio = neg ? -longint'(q) : longint'(q);
      uw = ratio;
      lw = 65536 - ratio;
      if (uw > 64'sh7fffffff) begin uw = 64'sh7fffffff; sat = 1; end
      if (uw < -64'sh80000000) begin uw = -64'sh80000000; sat = 1; end
      if (lw > 64'sh7fffffff) begin lw = 64'sh7fffffff; sat = 1; end
      if (lw < -64'sh80000000) begin lw = -64'sh80000000; sat = 1; end
      r.lw = lw[31:0];
      r.uw = uw[31:0];
      r.st = sat ? lerp_pkg::ST_SAT : lerp_pkg::ST_OK;
    end
    return r;
  endfunction

  function automatic stim_t wr(input int idx, input logic [31:0] v);
    stim_t s;
    s = '{op: lerp_pkg::OP_WRITE, idx: idx[3:0], val: v, x: $urandom, typed: 0,
          w: '{0, 0, 0, 0, 0}};
    return s;
  endfunction

  function automatic stim_t qry(input logic [31:0] x);
    stim_t s;
    s = '{op: lerp_pkg::OP_QUERY, idx: $urandom, val: $urandom, x: x, typed: 0,
          w: '{0, 0, 0, 0, 0}};
    return s;
  endfunction

  function automatic stim_t qry_exp(input logic [31:0] x, input logic [3:0] lo,
                                    input logic [31:0] lw, input logic [31:0] uw,
                                    input logic [1:0] st);
    stim_t s;
    s = qry(x);
    s.typed = 1;
    s.w = '{lo, lo + 4'd1, lw, uw, st};
    return s;
  endfunction

  function automatic void add_row(input stim_t s);
    directed.insert(directed.size(), s);
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;

  task automatic send(input stim_t s);
    weights_t w;
    if (burst_left == 0) begin
      if (s_tvalid) s_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1;
    s_tuser  <= s.op;
    s_tdata  <= {4'd0, s.x, s.val, s.idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
    if (s.op == lerp_pkg::OP_WRITE) begin
      bp_tbl[s.idx] = s.val;
    end else begin
      w = s.typed ? s.w : interp_weights(s.x);
      pending_q.insert(pending_q.size(), w);
    end
    @(negedge clk);
  endtask

  task automatic drain_idle();
    if (s_tvalid) s_tvalid <= 0;
    burst_left = 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_count(input logic [4:0] v);
    drain_idle();
    psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= {27'd0, v}; penable <= 0;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    count_reg = v;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: v = $urandom_range(0, 32'h80000) - 32'h40000;
      default: v = bp_tbl[$urandom_range(0, 15)] + $urandom_range(0, 32'h20000) - 32'h10000;
    endcase
    return v;
  endfunction

  // receiver: own stall pattern plus a long hold on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 400;
      m_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else begin
      case (cycles[9:7])
        3'd0, 3'd4: m_tready <= 1;
        3'd2: m_tready <= ($urandom_range(0, 7) == 0);
        default: m_tready <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        weights_t e;
        e = pending_q.pop_front();
        n_results++;
        if (m_tdata[3:0] !== e.lo || m_tdata[7:4] !== e.hi || m_tdata[39:8] !== e.lw ||
            m_tdata[71:40] !== e.uw || m_tdata[73:72] !== e.st || m_tdata[79:74] !== '0) begin
          $display("%0t: mismatch expected lo=%0d hi=%0d lw=%h uw=%h st=%0d", $time,
                   e.lo, e.hi, e.lw, e.uw, e.st);
          $display("%0t:          actual lo=%0d hi=%0d lw=%h uw=%h st=%0d", $time,
                   m_tdata[3:0], m_tdata[7:4], m_tdata[39:8], m_tdata[71:40], m_tdata[73:72]);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    stim_t s;
    logic [4:0] counts [10] = '{5'd2, 5'd16, 5'd0, 5'd1, 5'd17, 5'd31, 5'd7, 5'd12, 5'd3, 5'd16};
    logic [31:0] base, step;

    for (int i = 0; i < lerp_pkg::MAX_POINTS; i++) bp_tbl[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: fill the table first, point_count is 2 after reset
    add_row(wr(0, 32'd0));
    for (int i = 1; i < lerp_pkg::MAX_POINTS; i++) add_row(wr(i, i * 32'h10000));
    add_row(qry_exp(32'h8000, 4'd0, 32'h8000, 32'h8000, lerp_pkg::ST_OK));
    add_row(qry_exp(32'h0, 4'd0, 32'h10000, 32'h0, lerp_pkg::ST_OK));
    add_row(qry_exp(32'h10000, 4'd0, 32'h0, 32'h10000, lerp_pkg::ST_OK));
    add_row(qry_exp(32'h80000000, 4'd0, 32'h7fffffff, 32'h80000000, lerp_pkg::ST_SAT));
    add_row(qry(32'h7fffffff));
    add_row(wr(1, 32'd0));        // equal bracketing pair
    add_row(qry_exp(32'd5, 4'd0, 32'h0, 32'h0, lerp_pkg::ST_EQUAL));
    add_row(wr(0, 32'h80000000));
    add_row(wr(1, 32'h7fffffff));
    add_row(qry(32'h12345678));
    add_row(qry(32'h80000000));
    add_row(wr(0, 32'd0));
    add_row(wr(1, 32'h10000));
    foreach (directed[i]) send(directed[i]);

    for (int ph = 0; ph < 10; ph++) begin
      write_count(counts[ph]);
      // table built from random non-negative steps (may wrap), some equal neighbors
      base = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h100000) - 32'h80000;
      for (int i = 0; i < lerp_pkg::MAX_POINTS; i++) begin
        send(wr(i, base));
        step = $urandom_range(0, 7) == 0 ? 32'd0 : $urandom_range(1, 32'h40000);
        base = base + step;
      end
      if (ph == 3) hold_req++;
      for (int k = 0; k < 150; k++) begin
        if (ph == 5 && k == 75) begin
          if (s_tvalid) s_tvalid <= 0;
          burst_left = 0;
          while (pending_q.size() != 0) @(negedge clk);
        end
        if ($urandom_range(0, 9) < 7) s = qry(pick_value());
        else s = wr($urandom_range(0, 15), pick_value());
        send(s);
      end
    end

    if (s_tvalid) s_tvalid <= 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d transactions and %0d weight results over %0d point_count settings",
             n_items, n_results, 10);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors", errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
